// ----- hdl/hwa_pkg.sv -----
`default_nettype none
package hwa_pkg;

	// Q8.24 fixed point
	localparam int Q_FRAC = 24;
	// running window sum
	localparam int SUM_W = 40;
	// divider: magnitude width, bits resolved per stage, stage count
	localparam int DVW = 40;
	localparam int DIV_STEP = 4;
	localparam int NDS = DVW / DIV_STEP;

	typedef enum logic [2:0] {
		REG_HOLE_MODE = 3'd0,
		REG_OFFDIAG_SCALE = 3'd1,
		REG_WINDOW_LEN = 3'd2,
		REG_REORG_LAMBDA = 3'd3,
		REG_FREEZE_VALUE = 3'd4,
		REG_OCC_MODE = 3'd5
	} cfg_reg_t;

	// item fields that ride alongside the divider
	typedef struct packed {
		logic [3:0] row;
		logic [3:0] col;
		logic last;
		logic is_diag;
		logic bypass;
		logic signed [31:0] aux;
		logic signed [39:0] term;
	} side_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
		if (x > 66'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (x < -66'sd2147483648) begin
			return 32'sh80000000;
		end
		return x[31:0];
	endfunction

	function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [65:0] x);
		if (x > 66'sd549755813887) begin
			return {1'b0, {(SUM_W-1){1'b1}}};
		end else if (x < -66'sd549755813888) begin
			return {1'b1, {(SUM_W-1){1'b0}}};
		end
		return x[SUM_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ----- hdl/hwa_ram.sv -----
`default_nettype none
module hwa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- hdl/hamiltonian_window_average_core.sv -----
`default_nettype none
// Pipeline: 3 front stages, NDS = 10 divider stages and an output register lie between
// input item and result item. Throughput: one item per cycle, set by the fully
// pipelined window-mean divider; a stalled output halts every stage in place.
// Reset (arst_n low, asynchronous): config back to defaults, window sums, fill
// values, site ages and ring position cleared; ring RAM is not cleared.
module hamiltonian_window_average_core
	import hwa_pkg::*;
#(
	parameter int MAX_SITES = 16,
	parameter int MAX_WINDOW = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	// config write port
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [31:0] cfg_data,
	// input items
	input wire logic s_tvalid,
	output logic s_tready,
	// row_index[3:0], col_index[7:4], ham_value[39:8], site_shift[71:40],
	// amp_real[103:72], amp_imag[135:104], occupation_given[167:136]
	input wire logic [167:0] s_tdata,
	// window_restart: fill the site's whole window with this value
	input wire logic s_tuser,
	// end_of_matrix
	input wire logic s_tlast,
	// result items
	output logic m_tvalid,
	input wire logic m_tready,
	// out_row[3:0], out_col[7:4], out_value[39:8]
	output logic [39:0] m_tdata,
	// out_last
	output logic m_tlast
);

	localparam int LW = $clog2(MAX_WINDOW + 1);
	localparam int WW = MAX_WINDOW > 1 ? $clog2(MAX_WINDOW) : 1;
	localparam int PW = WW + 2;
	localparam int SIW = MAX_SITES > 1 ? $clog2(MAX_SITES) : 1;
	localparam int RDEPTH = MAX_SITES * MAX_WINDOW;
	localparam int AW = RDEPTH > 1 ? $clog2(RDEPTH) : 1;
	localparam int DLW = 32 + LW + 1;

	typedef struct packed {
		logic neg;
		logic [DVW-1:0] nq;   // dividend bits shifted out at top, quotient shifted in
		logic [LW-1:0] rem;
	} div_t;

	function automatic div_t div_step(input div_t x, input logic [LW-1:0] l);
		logic [LW:0] r;
		logic ge;
		for (int i = 0; i < DIV_STEP; i++) begin
			r = {x.rem, x.nq[DVW-1]};
			ge = r >= {1'b0, l};
			x.nq = {x.nq[DVW-2:0], ge};
			x.rem = ge ? LW'(r - {1'b0, l}) : LW'(r);
		end
		return x;
	endfunction

	// ---------------- configuration ----------------
	logic hole_mode_q;
	logic signed [31:0] offdiag_scale_q;
	logic [6:0] window_len_q;
	logic signed [31:0] reorg_lambda_q;
	logic signed [31:0] freeze_value_q;
	logic occ_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hole_mode_q <= 1'b0;
			offdiag_scale_q <= 32'sd16777216;
			window_len_q <= 7'd1;
			reorg_lambda_q <= '0;
			freeze_value_q <= '0;
			occ_mode_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_HOLE_MODE: hole_mode_q <= cfg_data[0];
				REG_OFFDIAG_SCALE: offdiag_scale_q <= cfg_data;
				REG_WINDOW_LEN: window_len_q <= cfg_data[6:0];
				REG_REORG_LAMBDA: reorg_lambda_q <= cfg_data;
				REG_FREEZE_VALUE: freeze_value_q <= cfg_data;
				REG_OCC_MODE: occ_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// effective window: zero reads as one, clipped to MAX_WINDOW
	logic [LW-1:0] l_eff;
	always_comb begin
		if (window_len_q == 7'd0) begin
			l_eff = LW'(1);
		end else if (int'(window_len_q) > MAX_WINDOW) begin
			l_eff = LW'(MAX_WINDOW);
		end else begin
			l_eff = LW'(window_len_q);
		end
	end

	// global advance: the whole pipe moves unless the output item is stuck
	logic en;
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	logic acc;
	assign acc = s_tvalid && s_tready;

	// ---------------- stage 0: unpack, diagonal value, per-site age/fill ----------------
	logic [3:0] in_row, in_col;
	logic signed [31:0] in_ham, in_shift, in_ar, in_ai, in_og;
	assign in_row = s_tdata[3:0];
	assign in_col = s_tdata[7:4];
	assign in_ham = s_tdata[39:8];
	assign in_shift = s_tdata[71:40];
	assign in_ar = s_tdata[103:72];
	assign in_ai = s_tdata[135:104];
	assign in_og = s_tdata[167:136];

	logic [WW-1:0] ring_pos_q;
	logic [LW-1:0] age_q [MAX_SITES];
	logic signed [31:0] fill_q [MAX_SITES];
	logic signed [SUM_W-1:0] sum_q [MAX_SITES];

	logic signed [33:0] d_wide;
	logic signed [31:0] d0;
	logic in_diag, in_win;
	logic [SIW-1:0] in_site;
	logic [PW-1:0] lpos;
	logic [WW-1:0] rpos;
	logic [AW-1:0] base0;
	logic [LW:0] age_inc;
	logic use_ring0;

	always_comb begin
		d_wide = (hole_mode_q ? -34'(in_ham) : 34'(in_ham)) + 34'(in_shift);
		d0 = sat32(66'(d_wide));
		in_diag = in_row == in_col;
		in_win = in_diag && (int'(in_row) < MAX_SITES);
		in_site = SIW'(in_row);
		// leaving entry sits L positions behind the write position
		lpos = PW'(ring_pos_q) + PW'(MAX_WINDOW) - PW'(l_eff);
		if (lpos >= PW'(MAX_WINDOW)) begin
			lpos = lpos - PW'(MAX_WINDOW);
		end
		rpos = WW'(lpos);
		base0 = AW'(AW'(in_site) * AW'(MAX_WINDOW));
		age_inc = {1'b0, age_q[in_site]} + (LW+1)'(1);
		use_ring0 = age_q[in_site] >= l_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_pos_q <= '0;
			for (int i = 0; i < MAX_SITES; i++) begin
				age_q[i] <= '0;
				fill_q[i] <= '0;
			end
		end else if (acc) begin
			if (s_tlast) begin
				ring_pos_q <= (int'(ring_pos_q) == MAX_WINDOW - 1) ? '0 : WW'(ring_pos_q + 1'b1);
			end
			if (in_win) begin
				if (s_tuser) begin
					age_q[in_site] <= LW'(1);
					fill_q[in_site] <= d0;
				end else begin
					age_q[in_site] <= (age_inc > {1'b0, l_eff}) ? l_eff : LW'(age_inc);
				end
			end
		end
	end

	// ---------------- stage 1: ring access, products ----------------
	logic v_s1;
	logic [3:0] row_s1, col_s1;
	logic last_s1, first_s1, diag_s1, win_s1, use_ring_s1;
	logic [SIW-1:0] site_s1;
	logic signed [31:0] d_s1, ham_s1, ar_s1, ai_s1, og_s1, fill_s1;
	logic [AW-1:0] raddr_s1, waddr_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			row_s1 <= in_row;
			col_s1 <= in_col;
			last_s1 <= s_tlast;
			first_s1 <= s_tuser;
			diag_s1 <= in_diag;
			win_s1 <= in_win;
			use_ring_s1 <= use_ring0 && !s_tuser;
			site_s1 <= in_site;
			d_s1 <= d0;
			ham_s1 <= in_ham;
			ar_s1 <= in_ar;
			ai_s1 <= in_ai;
			og_s1 <= in_og;
			fill_s1 <= fill_q[in_site];
			raddr_s1 <= base0 + AW'(rpos);
			waddr_s1 <= base0 + AW'(ring_pos_q);
		end
	end

	logic ram_act;
	logic [31:0] ram_rd;
	assign ram_act = en && v_s1 && win_s1;

	hwa_ram #(
		.WIDTH(32),
		.DEPTH(RDEPTH)
	) u_ring (
		.clk(clk),
		.we(ram_act),
		.waddr(waddr_s1),
		.wdata(d_s1),
		.re(ram_act),
		.raddr(raddr_s1),
		.rdata(ram_rd)
	);

	logic [31:0] abs_ar, abs_ai;
	always_comb begin
		abs_ar = ar_s1[31] ? 32'(-ar_s1) : ar_s1;
		abs_ai = ai_s1[31] ? 32'(-ai_s1) : ai_s1;
	end

	// ---------------- stage 2: window sum update, occupation, off-diagonal ----------------
	logic v_s2;
	logic [3:0] row_s2, col_s2;
	logic last_s2, first_s2, diag_s2, win_s2, use_ring_s2;
	logic [SIW-1:0] site_s2;
	logic signed [31:0] d_s2, og_s2, fill_s2;
	logic signed [DLW-1:0] dl_s2;
	logic [63:0] sqa_s2, sqb_s2;
	logic signed [63:0] offp_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			row_s2 <= row_s1;
			col_s2 <= col_s1;
			last_s2 <= last_s1;
			first_s2 <= first_s1;
			diag_s2 <= diag_s1;
			win_s2 <= win_s1;
			use_ring_s2 <= use_ring_s1;
			site_s2 <= site_s1;
			d_s2 <= d_s1;
			og_s2 <= og_s1;
			fill_s2 <= fill_s1;
			dl_s2 <= DLW'(d_s1) * $signed({1'b0, l_eff});
			sqa_s2 <= abs_ar * abs_ar;
			sqb_s2 <= abs_ai * abs_ai;
			offp_s2 <= ham_s1 * offdiag_scale_q;
		end
	end

	logic signed [31:0] leaving;
	logic signed [SUM_W-1:0] sum_new;
	logic [64:0] sq_sum;
	logic [40:0] sq_shr;
	logic signed [31:0] occ2;
	logic signed [63:0] offp_sgn;
	logic signed [39:0] off_shr;
	logic signed [31:0] off_res;
	logic adj;

	always_comb begin
		leaving = use_ring_s2 ? $signed(ram_rd) : fill_s2;
		if (first_s2) begin
			sum_new = sat_sum(66'(dl_s2));
		end else begin
			sum_new = sat_sum(66'(sum_q[site_s2]) + 66'(d_s2) - 66'(leaving));
		end
		sq_sum = {1'b0, sqa_s2} + {1'b0, sqb_s2};
		sq_sum = sq_sum >> Q_FRAC;
		sq_shr = sq_sum[40:0];
		if (occ_mode_q) begin
			occ2 = og_s2;
		end else if (sq_shr > 41'h07fffffff) begin
			occ2 = 32'sh7fffffff;
		end else begin
			occ2 = sq_shr[31:0];
		end
		offp_sgn = hole_mode_q ? -offp_s2 : offp_s2;
		off_shr = 40'(offp_sgn >>> Q_FRAC);
		adj = ({1'b0, col_s2} == {1'b0, row_s2} + 5'd1)
			|| ({1'b0, row_s2} == {1'b0, col_s2} + 5'd1);
		if (freeze_value_q != 32'sd0) begin
			off_res = adj ? freeze_value_q : 32'sd0;
		end else begin
			off_res = sat32(66'(off_shr));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_SITES; i++) begin
				sum_q[i] <= '0;
			end
		end else if (en && v_s2 && win_s2) begin
			sum_q[site_s2] <= sum_new;
		end
	end

	// ---------------- stage 3: reorganisation term, divider set-up ----------------
	logic v_s3;
	logic [3:0] row_s3, col_s3;
	logic last_s3, diag_s3, bypass_s3;
	logic signed [SUM_W-1:0] sum_s3;
	logic signed [31:0] occ_s3, aux_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			row_s3 <= row_s2;
			col_s3 <= col_s2;
			last_s3 <= last_s2;
			diag_s3 <= diag_s2;
			bypass_s3 <= diag_s2 && !win_s2;
			sum_s3 <= sum_new;
			occ_s3 <= occ2;
			aux_s3 <= diag_s2 ? d_s2 : off_res;
		end
	end

	logic signed [63:0] term_prod;
	div_t div_init;
	side_t side3;
	always_comb begin
		term_prod = occ_s3 * reorg_lambda_q;
		div_init.neg = sum_s3[SUM_W-1];
		div_init.nq = sum_s3[SUM_W-1] ? DVW'(-sum_s3) : DVW'(sum_s3);
		div_init.rem = '0;
		side3.row = row_s3;
		side3.col = col_s3;
		side3.last = last_s3;
		side3.is_diag = diag_s3;
		side3.bypass = bypass_s3;
		side3.aux = aux_s3;
		side3.term = 40'(term_prod >>> Q_FRAC);
	end

	// ---------------- stages 4..3+NDS: window mean divider ----------------
	div_t div_s4 [NDS];
	side_t side_s4 [NDS];
	logic vd_s4 [NDS];

	always_ff @(posedge clk) begin
		if (en) begin
			div_s4[0] <= div_step(div_init, l_eff);
			side_s4[0] <= side3;
			for (int k = 1; k < NDS; k++) begin
				div_s4[k] <= div_step(div_s4[k-1], l_eff);
				side_s4[k] <= side_s4[k-1];
			end
		end
	end

	// ---------------- final: diagonals subtract term and saturate, others pass ----------------
	div_t dfin;
	side_t sfin;
	logic signed [40:0] mean;
	logic signed [31:0] res;
	always_comb begin
		dfin = div_s4[NDS-1];
		sfin = side_s4[NDS-1];
		mean = dfin.neg ? -$signed({1'b0, dfin.nq}) : $signed({1'b0, dfin.nq});
		if (!sfin.is_diag) begin
			res = sfin.aux;
		end else if (sfin.bypass) begin
			res = sat32(66'(sfin.aux) - 66'(sfin.term));
		end else begin
			res = sat32(66'(mean) - 66'(sfin.term));
		end
	end

	logic [3:0] out_row_q, out_col_q;
	logic signed [31:0] out_value_q;
	logic out_last_q;

	always_ff @(posedge clk) begin
		if (en) begin
			out_row_q <= sfin.row;
			out_col_q <= sfin.col;
			out_value_q <= res;
			out_last_q <= sfin.last;
		end
	end

	assign m_tdata = {out_value_q, out_col_q, out_row_q};
	assign m_tlast = out_last_q;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			for (int k = 0; k < NDS; k++) begin
				vd_s4[k] <= 1'b0;
			end
			m_tvalid <= 1'b0;
		end else if (en) begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			vd_s4[0] <= v_s3;
			for (int k = 1; k < NDS; k++) begin
				vd_s4[k] <= vd_s4[k-1];
			end
			m_tvalid <= vd_s4[NDS-1];
		end
	end

endmodule
`default_nettype wire

// ----- verif/tb_hamiltonian_window_average_core.sv -----
`default_nettype none
module tb_hamiltonian_window_average_core;
	import hwa_pkg::*;

	localparam int N_SITES = 16;
	localparam int N_WIN = 64;

	// one assembled element as it leaves the block
	typedef struct {
		logic [3:0] row;
		logic [3:0] col;
		logic signed [31:0] value;
		logic last;
	} elem_t;

	// Assembly model with its own copy of registers and window state.
	class ham_scoreboard;
		bit hole;
		longint scale, lambda, freeze;
		int unsigned wlen;
		bit occ_given_mode;
		int ring [N_SITES][N_WIN];
		bit written [N_SITES][N_WIN];
		longint wsum [N_SITES];
		int fillv [N_SITES];
		int unsigned age [N_SITES];
		int unsigned pos;
		elem_t pending [$];
		int errors;
		int matched;

		function void clear();
			hole = 0; scale = 16777216; wlen = 1; lambda = 0; freeze = 0;
			occ_given_mode = 0; pos = 0; errors = 0; matched = 0;
			foreach (wsum[i]) begin
				wsum[i] = 0; fillv[i] = 0; age[i] = 0;
			end
			foreach (written[i, j]) written[i][j] = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [31:0] v);
			case (idx)
				REG_HOLE_MODE: hole = v[0];
				REG_OFFDIAG_SCALE: scale = longint'($signed(v));
				REG_WINDOW_LEN: wlen = v[6:0];
				REG_REORG_LAMBDA: lambda = longint'($signed(v));
				REG_FREEZE_VALUE: freeze = longint'($signed(v));
				REG_OCC_MODE: occ_given_mode = v[0];
				default: ;
			endcase
		endfunction

		static function longint clip32(longint x);
			if (x > 64'sd2147483647) return 64'sd2147483647;
			if (x < -64'sd2147483648) return -64'sd2147483648;
			return x;
		endfunction

		static function longint clip40(longint x);
			if (x > 64'sd549755813887) return 64'sd549755813887;
			if (x < -64'sd549755813888) return -64'sd549755813888;
			return x;
		endfunction

		// arithmetic shift on a 64-bit signed value floors, as required
		static function longint qmul_floor(longint x);
			return x >>> 24;
		endfunction

		// true when a plain diagonal step of site r would take its leaving
		// entry from a ring slot that has never been written
		function bit reads_unwritten(logic [3:0] r);
			int unsigned l;
			l = wlen == 0 ? 1 : (wlen > N_WIN ? N_WIN : wlen);
			return age[r] >= l && !written[r][(pos + N_WIN - l) % N_WIN];
		endfunction

		function void note_item(logic [167:0] d, logic first, logic last);
			logic [3:0] r, c;
			longint ham, sh, ar, ai, og, dv, occ, mean, res;
			longint unsigned a, b, s;
			int unsigned l;
			elem_t e;
			r = d[3:0]; c = d[7:4];
			ham = longint'($signed(d[39:8]));
			sh = longint'($signed(d[71:40]));
			ar = longint'($signed(d[103:72]));
			ai = longint'($signed(d[135:104]));
			og = longint'($signed(d[167:136]));
			if (r == c) begin
				dv = clip32((hole ? -ham : ham) + sh);
				if (occ_given_mode) occ = og;
				else begin
					a = ar < 0 ? -ar : ar;
					b = ai < 0 ? -ai : ai;
					s = (a * a + b * b) >> 24;
					occ = s > 64'd2147483647 ? 64'sd2147483647 : longint'(s);
				end
				l = wlen == 0 ? 1 : (wlen > N_WIN ? N_WIN : wlen);
				if (first) begin
					wsum[r] = clip40(dv * l);
					fillv[r] = int'(dv);
					age[r] = 1;
				end else begin
					longint leaving;
					leaving = age[r] >= l ? ring[r][(pos + N_WIN - l) % N_WIN] : fillv[r];
					wsum[r] = clip40(wsum[r] + dv - leaving);
					age[r] = age[r] + 1 > l ? l : age[r] + 1;
				end
				ring[r][pos] = int'(dv);
				written[r][pos] = 1;
				mean = wsum[r] / longint'(l);
				res = clip32(mean - qmul_floor(occ * lambda));
			end else if (freeze != 0) begin
				res = (c == r + 5'd1 || r == c + 5'd1) ? freeze : 0;
			end else begin
				longint p;
				p = ham * scale;
				if (hole) p = -p;
				res = clip32(qmul_floor(p));
			end
			if (last) pos = (pos + 1) % N_WIN;
			e.row = r; e.col = c; e.value = res[31:0]; e.last = last;
			pending.push_back(e);
		endfunction

		function void check_result(logic [39:0] d, logic last);
			elem_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h last %b", $time, d, last);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (d[3:0] !== e.row || d[7:4] !== e.col || d[39:8] !== e.value
					|| last !== e.last) begin
				$display("%0t: mismatch expected row %0d col %0d value %h last %b",
					$time, e.row, e.col, e.value, e.last);
				$display("%0t:          actual   row %0d col %0d value %h last %b",
					$time, d[3:0], d[7:4], d[39:8], last);
				errors++;
			end else matched++;
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [167:0] s_tdata = '0;
	logic s_tuser = 0;
	logic s_tlast = 0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [39:0] m_tdata;
	logic m_tlast;

	always #4 clk = ~clk;

	hamiltonian_window_average_core uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	ham_scoreboard sb;
	// idle percentages for sender and receiver, changed per phase
	int send_idle = 0;
	int recv_idle = 0;
	int n_items = 0;
	int n_diag = 0;
	// sites whose window has been opened by a first step since reset
	bit site_open [N_SITES];

	// receiver: stalls at random, checks at the rising edge
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
	end
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle);
	end

	task automatic write_reg(cfg_reg_t idx, logic [31:0] v);
		@(negedge clk);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
		@(posedge clk);
		sb.write_reg(idx, v);
		@(negedge clk);
		cfg_we <= 0;
	endtask

	// drop valid, then wait until every expected element has come, plus a settling wait
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// present one item; random gap first, held until accepted; valid stays up
	// so that the next item can follow in the very next cycle
	task automatic send(logic [3:0] r, logic [3:0] c, logic [31:0] ham, logic [31:0] sh,
			logic [31:0] ar, logic [31:0] ai, logic [31:0] og, logic first, logic last);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 0;
			@(negedge clk);
		end
		// a diagonal without an open window would read unwritten ring entries
		if (r == c && !site_open[r]) first = 1;
		if (r == c && !first && sb.reads_unwritten(r)) first = 1;
		if (r == c) begin
			site_open[r] = 1; n_diag++;
		end
		s_tvalid <= 1;
		s_tdata <= {og, ai, ar, sh, ham, c, r};
		s_tuser <= first; s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_item({og, ai, ar, sh, ham, c, r}, first, last);
		n_items++;
	endtask

	function automatic logic [31:0] rnd_val();
		case ($urandom_range(5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(0, 32'h03ffffff);
			3: return -$urandom_range(0, 32'h03ffffff);
			default: return $urandom;
		endcase
	endfunction

	// one matrix over the first n sites, upper triangle, a few stray items
	task automatic send_matrix(int n, bit first);
		for (int r = 0; r < n; r++)
			for (int c = r; c < n; c++) begin
				logic [3:0] rr, cc;
				rr = r; cc = c;
				// occasional column below row
				if (r != c && $urandom_range(9) == 0) begin
					rr = c; cc = r;
				end
				send(rr, cc, rnd_val(), rnd_val(), rnd_val(), rnd_val(), rnd_val(),
					first || $urandom_range(19) == 0, r == n - 1 && c == n - 1);
			end
	endtask

	task automatic random_config(bit extreme);
		write_reg(REG_HOLE_MODE, $urandom_range(1));
		write_reg(REG_OFFDIAG_SCALE, extreme ? 32'h80000000 : rnd_val());
		write_reg(REG_WINDOW_LEN, extreme ? 7'd64 : $urandom_range(0, 127));
		write_reg(REG_REORG_LAMBDA, extreme ? 32'h7fffffff : rnd_val());
		write_reg(REG_FREEZE_VALUE, $urandom_range(3) == 0 ? rnd_val() : 32'h0);
		write_reg(REG_OCC_MODE, $urandom_range(1));
	endtask

	initial begin
		sb = new();
		sb.clear();
		foreach (site_open[i]) site_open[i] = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		recv_idle = 0;

		// directed: field extremes, hole negation of the most negative value,
		// window length zero, freezing, site past the windowed range can't occur
		// with 4-bit rows, so the window corners are covered instead
		write_reg(REG_WINDOW_LEN, 7'd0);
		send(0, 0, 32'h80000000, 32'h0, 32'h7fffffff, 32'h80000000, 32'h0, 1, 0);
		send(0, 1, 32'h7fffffff, 32'h0, 0, 0, 0, 0, 0);
		send(15, 15, 32'hffffffff, 32'h7fffffff, 32'hffffffff, 32'hffffffff,
			32'h7fffffff, 1, 0);
		send(15, 14, 32'h80000000, 0, 0, 0, 0, 0, 1);
		drain();
		write_reg(REG_HOLE_MODE, 1);
		write_reg(REG_WINDOW_LEN, 7'd127);
		write_reg(REG_OCC_MODE, 1);
		write_reg(REG_REORG_LAMBDA, 32'h80000000);
		send(0, 0, 32'h80000000, 32'h80000000, 0, 0, 32'h80000000, 0, 0);
		send(0, 0, 32'h7fffffff, 32'h7fffffff, 0, 0, 32'h7fffffff, 0, 0);
		send(3, 5, 32'h80000000, 0, 0, 0, 0, 0, 1);
		drain();
		write_reg(REG_FREEZE_VALUE, 32'h80000000);
		send(4, 5, 1, 0, 0, 0, 0, 0, 0);
		send(5, 4, 1, 0, 0, 0, 0, 0, 0);
		send(4, 6, 1, 0, 0, 0, 0, 0, 0);
		send(4, 4, 32'h01000000, 0, 0, 0, 32'h01000000, 0, 1);
		drain();
		write_reg(REG_FREEZE_VALUE, 32'h0);
		write_reg(REG_OFFDIAG_SCALE, 32'h7fffffff);
		send(1, 2, 32'h7fffffff, 0, 0, 0, 0, 0, 0);
		send(1, 2, 32'h80000000, 0, 0, 0, 0, 0, 1);
		drain();

		// random matrices in three idling phases, new settings between
		for (int ph = 0; ph < 3; ph++) begin
			send_idle = ph == 0 ? 32 : (ph == 1 ? 56 : 0);
			recv_idle = ph == 0 ? 56 : (ph == 1 ? 32 : 0);
			for (int k = 0; k < 7; k++) begin
				random_config(k == 0);
				// a full 16-site matrix every third setting, two small ones with every setting
				if (k % 3 == 0) send_matrix(16, $urandom_range(7) == 0);
				repeat (2) send_matrix($urandom_range(1, 5), $urandom_range(7) == 0);
				drain();
			end
		end
		recv_idle = 0;
		drain();

		$display("Covered %0d items (%0d diagonal), %0d results checked,", n_items,
			n_diag, sb.matched);
		$display("across window lengths 0..127, hole and freeze modes, both occupation modes.");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb_hamiltonian_window_average_core: PASS");
		else
			$display("tb_hamiltonian_window_average_core: FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#8000000;
		$display("tb_hamiltonian_window_average_core: FAIL");
		$finish;
	end

endmodule
`default_nettype wire
